/* rtl/psua_pkg.sv */
// Shared types and constants for the per-shard usage accounting block.
// Used by every module under rtl except psua_ram; has no dependencies of its own.
`default_nettype none

package psua_pkg;

  localparam int CNT_W          = 48;
  localparam int ADD_W          = 32;
  localparam int SHARD_W        = 6;
  localparam int CMD_W          = 3;
  localparam int NUM_SHARDS_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_SHARD_CAP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_CAP = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD       = 3'd0,
    OP_QUERY     = 3'd1,
    OP_RESET     = 3'd2,
    OP_RESET_ALL = 3'd3,
    OP_LIST      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST,
    ST_LIST_END
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [SHARD_W-1:0] shard;
    logic [ADD_W-1:0]   add_bytes;
    logic [ADD_W-1:0]   add_points;
  } q_entry_t;

  typedef struct packed {
    logic [SHARD_W-1:0] out_shard;
    logic [CNT_W-1:0]   shard_bytes;
    logic [CNT_W-1:0]   shard_points;
    logic               shard_over_cap;
    logic               global_over_cap;
    logic [CNT_W-1:0]   total_bytes;
    logic [CNT_W-1:0]   total_points;
    logic               found;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/per_shard_usage_accounting.sv */
// Per-shard usage accounting: 48-bit saturating byte and point counters per shard plus totals.
// Add, query, reset shard and reset-all give one result each, after a counter RAM read.
// The back end takes one such command at a time, by read-modify-write of the counter RAM.
// List: one shard a cycle unless a stalled result holds it; a zero shard cap skips the walk.
// Reset (rst, synchronous): clears caps, totals and per-shard valid bits; no sweep.
// Depends on psua_pkg, psua_front, psua_back and psua_ram.
`default_nettype none

module per_shard_usage_accounting
  import psua_pkg::*;
#(
  parameter int NUM_SHARDS = NUM_SHARDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [SHARD_W-1:0]   shard,
  input  wire logic [ADD_W-1:0]     add_bytes,
  input  wire logic [ADD_W-1:0]     add_points,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic [SHARD_W-1:0]        out_shard,
  output logic [CNT_W-1:0]          shard_bytes,
  output logic [CNT_W-1:0]          shard_points,
  output logic                      shard_over_cap,
  output logic                      global_over_cap,
  output logic [CNT_W-1:0]          total_bytes,
  output logic [CNT_W-1:0]          total_points,
  output logic                      found,
  output logic                      last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);

  logic [CNT_W-1:0] shard_cap;
  logic [CNT_W-1:0] global_cap;
  logic             q_valid;
  q_entry_t         q_entry;
  logic             q_pop;
  res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shard_cap  <= '0;
      global_cap <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHARD_CAP:  shard_cap  <= cfg_data;
        CFG_GLOBAL_CAP: global_cap <= cfg_data;
        default: shard_cap <= shard_cap;
      endcase
    end
  end

  psua_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .shard      (shard),
    .add_bytes  (add_bytes),
    .add_points (add_points),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  psua_back #(
    .NUM_SHARDS (NUM_SHARDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .shard_cap  (shard_cap),
    .global_cap (global_cap),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  assign out_shard       = res.out_shard;
  assign shard_bytes     = res.shard_bytes;
  assign shard_points    = res.shard_points;
  assign shard_over_cap  = res.shard_over_cap;
  assign global_over_cap = res.global_over_cap;
  assign total_bytes     = res.total_bytes;
  assign total_points    = res.total_points;
  assign found           = res.found;
  assign last            = res.last;

endmodule

`default_nettype wire

/* rtl/psua_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/psua_front.sv */
// Front end: accepts commands, drops unknown codes, queues the rest.
// Depends on psua_pkg.
`default_nettype none

module psua_front
  import psua_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [SHARD_W-1:0] shard,
  input  wire logic [ADD_W-1:0]   add_bytes,
  input  wire logic [ADD_W-1:0]   add_points,
  output logic                    q_valid,
  output q_entry_t                q_entry,
  input  wire logic               q_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t          q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              known;
  logic              push;
  q_entry_t          entry_in;

  always_comb begin
    case (command) inside
      OP_ADD, OP_QUERY, OP_RESET, OP_RESET_ALL, OP_LIST: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign cmd_stall           = (count == QCNT_W'(QUEUE_DEPTH));
  assign push                = cmd_valid && !cmd_stall && known;
  assign entry_in.op         = op_t'(command);
  assign entry_in.shard      = shard;
  assign entry_in.add_bytes  = add_bytes;
  assign entry_in.add_points = add_points;

  assign q_valid = (count != '0);
  assign q_entry = q_mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + QCNT_W'(1);
    end else if (!push && q_pop) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/psua_back.sv */
// Back end: executes queued commands against the shard counter RAM,
// keeps the totals and valid bits, and drives the result register.
// Depends on psua_pkg and psua_ram.
`default_nettype none

module psua_back
  import psua_pkg::*;
#(
  parameter int NUM_SHARDS = NUM_SHARDS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] shard_cap,
  input  wire logic [CNT_W-1:0] global_cap,
  input  wire logic             q_valid,
  input  wire q_entry_t         q_entry,
  output logic                  q_pop,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output res_t                  res
);

  localparam int ADDR_W = $clog2(NUM_SHARDS);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_SHARDS - 1);

  state_t state;
  state_t state_next;

  op_t                cur_op;
  logic [SHARD_W-1:0] cur_shard;
  logic [ADD_W-1:0]   cur_ab;
  logic [ADD_W-1:0]   cur_ap;
  logic               cur_in_range;
  logic [ADDR_W-1:0]  cur_addr;

  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  idx_next;
  logic               pend_valid;
  logic [ADDR_W-1:0]  pend_id;
  logic [CNT_W-1:0]   pend_b;
  logic [CNT_W-1:0]   pend_p;
  logic               pend_load;
  logic               pend_clear;

  logic [CNT_W-1:0]   bytes_total;
  logic [CNT_W-1:0]   points_total;
  logic [CNT_W-1:0]   bytes_total_next;
  logic [CNT_W-1:0]   points_total_next;
  logic [NUM_SHARDS-1:0] valid_bits;
  logic               set_valid;
  logic               clr_one;
  logic               clr_all;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_ok;
  logic               rd_hit;
  logic [2*CNT_W-1:0] rd_data;
  logic               wr_en;
  logic [2*CNT_W-1:0] wr_data;

  logic               pop_in_range;
  logic               out_free;
  logic               emit;
  res_t               res_next;

  logic [CNT_W-1:0]   hit_b;
  logic [CNT_W-1:0]   hit_p;
  logic [CNT_W-1:0]   exec_b;
  logic [CNT_W-1:0]   exec_p;
  logic [CNT_W:0]     sum_b;
  logic [CNT_W:0]     sum_p;
  logic [CNT_W:0]     sum_tb;
  logic [CNT_W:0]     sum_tp;
  logic [CNT_W-1:0]   sat_b;
  logic [CNT_W-1:0]   sat_p;
  logic [CNT_W-1:0]   sat_tb;
  logic [CNT_W-1:0]   sat_tp;
  logic [CNT_W-1:0]   sub_tb;
  logic [CNT_W-1:0]   sub_tp;
  logic [CNT_W-1:0]   rb;
  logic [CNT_W-1:0]   rp;
  logic               cand;
  logic               blocked;

  psua_ram #(
    .WIDTH (2 * CNT_W),
    .DEPTH (NUM_SHARDS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cur_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign cur_addr     = cur_shard[ADDR_W-1:0];
  assign pop_in_range = ({1'b0, q_entry.shard} < (SHARD_W + 1)'(NUM_SHARDS));
  assign out_free     = !res_valid || !res_stall;

  assign hit_b  = rd_hit ? rd_data[2*CNT_W-1:CNT_W] : '0;
  assign hit_p  = rd_hit ? rd_data[CNT_W-1:0] : '0;
  assign exec_b = cur_in_range ? hit_b : '0;
  assign exec_p = cur_in_range ? hit_p : '0;

  assign sum_b  = {1'b0, exec_b} + (CNT_W + 1)'(cur_ab);
  assign sum_p  = {1'b0, exec_p} + (CNT_W + 1)'(cur_ap);
  assign sum_tb = {1'b0, bytes_total} + (CNT_W + 1)'(cur_ab);
  assign sum_tp = {1'b0, points_total} + (CNT_W + 1)'(cur_ap);
  assign sat_b  = sum_b[CNT_W] ? CNT_MAX : sum_b[CNT_W-1:0];
  assign sat_p  = sum_p[CNT_W] ? CNT_MAX : sum_p[CNT_W-1:0];
  assign sat_tb = sum_tb[CNT_W] ? CNT_MAX : sum_tb[CNT_W-1:0];
  assign sat_tp = sum_tp[CNT_W] ? CNT_MAX : sum_tp[CNT_W-1:0];
  assign sub_tb = (bytes_total > exec_b) ? bytes_total - exec_b : '0;
  assign sub_tp = (points_total > exec_p) ? points_total - exec_p : '0;
  assign wr_data = {sat_b, sat_p};

  assign cand    = (shard_cap != '0) && (hit_b >= shard_cap);
  assign blocked = cand && pend_valid && !out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_entry.op == OP_LIST) begin
            state_next = (shard_cap != '0) ? ST_LIST : ST_LIST_END;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (!blocked && idx == LAST_IDX) begin
          state_next = ST_LIST_END;
        end
      end
      ST_LIST_END: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop             = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = idx;
    rd_ok             = 1'b1;
    idx_next          = idx;
    pend_load         = 1'b0;
    pend_clear        = 1'b0;
    wr_en             = 1'b0;
    set_valid         = 1'b0;
    clr_one           = 1'b0;
    clr_all           = 1'b0;
    bytes_total_next  = bytes_total;
    points_total_next = points_total;
    rb                = '0;
    rp                = '0;
    emit              = 1'b0;
    res_next          = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          rd_en      = 1'b1;
          idx_next   = '0;
          pend_clear = 1'b1;
          if (q_entry.op == OP_LIST) begin
            rd_addr = '0;
          end else begin
            rd_addr = q_entry.shard[ADDR_W-1:0];
            rd_ok   = pop_in_range;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          unique case (cur_op)
            OP_ADD: begin
              if (cur_in_range) begin
                wr_en             = 1'b1;
                set_valid         = 1'b1;
                bytes_total_next  = sat_tb;
                points_total_next = sat_tp;
                rb                = sat_b;
                rp                = sat_p;
              end
            end
            OP_QUERY: begin
              rb = exec_b;
              rp = exec_p;
            end
            OP_RESET: begin
              if (cur_in_range) begin
                clr_one           = 1'b1;
                bytes_total_next  = sub_tb;
                points_total_next = sub_tp;
              end
            end
            OP_RESET_ALL: begin
              clr_all           = 1'b1;
              bytes_total_next  = '0;
              points_total_next = '0;
            end
            default: begin
              rb = '0;
            end
          endcase
          res_next.out_shard       = cur_shard;
          res_next.shard_bytes     = rb;
          res_next.shard_points    = rp;
          res_next.shard_over_cap  = (shard_cap != '0) && (rb >= shard_cap);
          res_next.global_over_cap = (global_cap != '0) && (bytes_total_next >= global_cap);
          res_next.total_bytes     = bytes_total_next;
          res_next.total_points    = points_total_next;
          res_next.found           = 1'b0;
          res_next.last            = 1'b1;
        end
      end
      ST_LIST: begin
        if (!blocked) begin
          if (cand) begin
            pend_load = 1'b1;
            if (pend_valid) begin
              emit = 1'b1;
            end
          end
          if (idx != LAST_IDX) begin
            idx_next = idx + ADDR_W'(1);
            rd_en    = 1'b1;
            rd_addr  = idx + ADDR_W'(1);
          end
        end
        res_next.out_shard       = SHARD_W'(pend_id);
        res_next.shard_bytes     = pend_b;
        res_next.shard_points    = pend_p;
        res_next.shard_over_cap  = 1'b1;
        res_next.global_over_cap = (global_cap != '0) && (bytes_total >= global_cap);
        res_next.total_bytes     = bytes_total;
        res_next.total_points    = points_total;
        res_next.found           = 1'b1;
        res_next.last            = 1'b0;
      end
      ST_LIST_END: begin
        emit = out_free;
        res_next.out_shard       = pend_valid ? SHARD_W'(pend_id) : '0;
        res_next.shard_bytes     = pend_valid ? pend_b : '0;
        res_next.shard_points    = pend_valid ? pend_p : '0;
        res_next.shard_over_cap  = pend_valid;
        res_next.global_over_cap = (global_cap != '0) && (bytes_total >= global_cap);
        res_next.total_bytes     = bytes_total;
        res_next.total_points    = points_total;
        res_next.found           = pend_valid;
        res_next.last            = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pend_valid   <= 1'b0;
      bytes_total  <= '0;
      points_total <= '0;
      valid_bits   <= '0;
      rd_hit       <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      bytes_total  <= bytes_total_next;
      points_total <= points_total_next;
      if (pend_clear) begin
        pend_valid <= 1'b0;
      end else if (pend_load) begin
        pend_valid <= 1'b1;
      end
      if (clr_all) begin
        valid_bits <= '0;
      end else if (set_valid) begin
        valid_bits[cur_addr] <= 1'b1;
      end else if (clr_one) begin
        valid_bits[cur_addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_hit <= rd_ok && valid_bits[rd_addr];
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (q_pop) begin
      cur_op       <= q_entry.op;
      cur_shard    <= q_entry.shard;
      cur_ab       <= q_entry.add_bytes;
      cur_ap       <= q_entry.add_points;
      cur_in_range <= pop_in_range;
    end
    if (pend_load) begin
      pend_id <= idx;
      pend_b  <= hit_b;
      pend_p  <= hit_p;
    end
    if (emit) begin
      res <= res_next;
    end
  end

  a_list_pend_over: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST || state == ST_LIST_END) && pend_valid
      |-> shard_cap != '0 && pend_b >= shard_cap)
    else $error("pending list entry is not over the shard cap");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> !emit)
    else $error("result register overwritten while stalled");

  a_reset_all_clears: assert property (@(posedge clk) disable iff (rst)
    emit && state == ST_EXEC && cur_op == OP_RESET_ALL
      |=> valid_bits == '0 && bytes_total == '0 && points_total == '0)
    else $error("reset-all left state behind");

  a_found_over_cap: assert property (@(posedge clk) disable iff (rst)
    emit && res_next.found |-> res_next.shard_over_cap)
    else $error("listed shard not flagged over cap");

  a_last_outside_walk: assert property (@(posedge clk) disable iff (rst)
    emit && state != ST_LIST |-> res_next.last)
    else $error("final result of a command lacks last");

endmodule

`default_nettype wire

/* bench/usage_checker.sv */
`timescale 1ns / 1ps
// Checker for per_shard_usage_accounting: watches the command, result and register channels,
// keeps its own copy of the shard counters and compares every result transfer field by field.
// Depends on psua_pkg.
module usage_checker
  import psua_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  input  wire logic                 cmd_stall,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [SHARD_W-1:0]   shard,
  input  wire logic [ADD_W-1:0]     add_bytes,
  input  wire logic [ADD_W-1:0]     add_points,
  input  wire logic                 res_valid,
  input  wire logic                 res_stall,
  input  wire logic [SHARD_W-1:0]   out_shard,
  input  wire logic [CNT_W-1:0]     shard_bytes,
  input  wire logic [CNT_W-1:0]     shard_points,
  input  wire logic                 shard_over_cap,
  input  wire logic                 global_over_cap,
  input  wire logic [CNT_W-1:0]     total_bytes,
  input  wire logic [CNT_W-1:0]     total_points,
  input  wire logic                 found,
  input  wire logic                 last,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data,
  output int                        mismatches,
  output int                        expected_left,
  output int                        results_checked
);

  localparam int SHARDS = NUM_SHARDS_DEF;

  logic [CNT_W-1:0] used_bytes [SHARDS];
  logic [CNT_W-1:0] used_points [SHARDS];
  logic [CNT_W-1:0] sum_bytes;
  logic [CNT_W-1:0] sum_points;
  logic [CNT_W-1:0] cap_shard;
  logic [CNT_W-1:0] cap_global;
  res_t             usage_expected [$];
  int               mismatch_total = 0;
  int               checked_total = 0;

  assign mismatches      = mismatch_total;
  assign results_checked = checked_total;

  function automatic logic [CNT_W-1:0] clamp_add(input logic [CNT_W-1:0] base,
                                                 input logic [ADD_W-1:0] amount);
    logic [CNT_W:0] sum;
    sum = {1'b0, base} + (CNT_W + 1)'(amount);
    return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

  function automatic res_t usage_record(input logic [SHARD_W-1:0] id,
                                        input logic [CNT_W-1:0] b, input logic [CNT_W-1:0] p,
                                        input logic hit, input logic fin);
    res_t r;
    r.out_shard       = id;
    r.shard_bytes     = b;
    r.shard_points    = p;
    r.shard_over_cap  = (cap_shard != '0) && (b >= cap_shard);
    r.global_over_cap = (cap_global != '0) && (sum_bytes >= cap_global);
    r.total_bytes     = sum_bytes;
    r.total_points    = sum_points;
    r.found           = hit;
    r.last            = fin;
    return r;
  endfunction

  task automatic queue_expected(input res_t r);
    usage_expected = {usage_expected, r};
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [SHARD_W-1:0] id,
                                 input logic [ADD_W-1:0] ab, input logic [ADD_W-1:0] ap);
    logic [CNT_W-1:0] b;
    logic [CNT_W-1:0] p;
    logic             in_range;
    int               final_hit;
    int               i;
    b         = '0;
    p         = '0;
    in_range  = int'(id) < SHARDS;
    final_hit = -1;
    case (cmd)
      OP_ADD: begin
        if (in_range) begin
          used_bytes[id]  = clamp_add(used_bytes[id], ab);
          used_points[id] = clamp_add(used_points[id], ap);
          sum_bytes       = clamp_add(sum_bytes, ab);
          sum_points      = clamp_add(sum_points, ap);
          b               = used_bytes[id];
          p               = used_points[id];
        end
        queue_expected(usage_record(id, b, p, 1'b0, 1'b1));
      end
      OP_QUERY: begin
        if (in_range) begin
          b = used_bytes[id];
          p = used_points[id];
        end
        queue_expected(usage_record(id, b, p, 1'b0, 1'b1));
      end
      OP_RESET: begin
        if (in_range) begin
          sum_bytes       = (sum_bytes > used_bytes[id]) ? sum_bytes - used_bytes[id] : '0;
          sum_points      = (sum_points > used_points[id]) ? sum_points - used_points[id] : '0;
          used_bytes[id]  = '0;
          used_points[id] = '0;
        end
        queue_expected(usage_record(id, '0, '0, 1'b0, 1'b1));
      end
      OP_RESET_ALL: begin
        for (i = 0; i < SHARDS; i++) begin
          used_bytes[i]  = '0;
          used_points[i] = '0;
        end
        sum_bytes  = '0;
        sum_points = '0;
        queue_expected(usage_record(id, '0, '0, 1'b0, 1'b1));
      end
      OP_LIST: begin
        if (cap_shard != '0) begin
          for (i = 0; i < SHARDS; i++) begin
            if (used_bytes[i] >= cap_shard) final_hit = i;
          end
        end
        if (final_hit < 0) begin
          queue_expected(usage_record('0, '0, '0, 1'b0, 1'b1));
        end else begin
          for (i = 0; i <= final_hit; i++) begin
            if (used_bytes[i] >= cap_shard) begin
              queue_expected(usage_record(SHARD_W'(i), used_bytes[i], used_points[i],
                                          1'b1, i == final_hit));
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    if (mismatch_total < 40) begin
      $display("MISMATCH at %0t ns: %s got %0h, want %0h", $time, what, got, want);
    end
    mismatch_total++;
  endtask

  task automatic compare_result();
    res_t want;
    if (usage_expected.size() == 0) begin
      report_mismatch("result transfer with nothing outstanding, out_shard",
                      CNT_W'(out_shard), '0);
    end else begin
      want = usage_expected.pop_front();
      checked_total++;
      if (out_shard !== want.out_shard)
        report_mismatch("out_shard", CNT_W'(out_shard), CNT_W'(want.out_shard));
      if (shard_bytes !== want.shard_bytes)
        report_mismatch("shard_bytes", shard_bytes, want.shard_bytes);
      if (shard_points !== want.shard_points)
        report_mismatch("shard_points", shard_points, want.shard_points);
      if (shard_over_cap !== want.shard_over_cap)
        report_mismatch("shard_over_cap", CNT_W'(shard_over_cap),
                        CNT_W'(want.shard_over_cap));
      if (global_over_cap !== want.global_over_cap)
        report_mismatch("global_over_cap", CNT_W'(global_over_cap),
                        CNT_W'(want.global_over_cap));
      if (total_bytes !== want.total_bytes)
        report_mismatch("total_bytes", total_bytes, want.total_bytes);
      if (total_points !== want.total_points)
        report_mismatch("total_points", total_points, want.total_points);
      if (found !== want.found)
        report_mismatch("found", CNT_W'(found), CNT_W'(want.found));
      if (last !== want.last)
        report_mismatch("last", CNT_W'(last), CNT_W'(want.last));
    end
  endtask

  always @(posedge clk) begin : track
    int k;
    if (rst) begin
      for (k = 0; k < SHARDS; k++) begin
        used_bytes[k]  = '0;
        used_points[k] = '0;
      end
      sum_bytes  = '0;
      sum_points = '0;
      cap_shard  = '0;
      cap_global = '0;
      usage_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SHARD_CAP) cap_shard = cfg_data;
        else if (cfg_index == CFG_GLOBAL_CAP) cap_global = cfg_data;
      end
      if (res_valid && !res_stall) compare_result();
      if (cmd_valid && !cmd_stall) predict_command(command, shard, add_bytes, add_points);
    end
    expected_left <= usage_expected.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Top of the per_shard_usage_accounting bench: clock, reset, command and register stimulus
// with random idling on both sides, and the verdict. Depends on psua_pkg and usage_checker.
module testbench;
  import psua_pkg::*;

  localparam int RUN_LIMIT     = 1_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int LOAD_ADDS     = 16;
  localparam int SETTLE_CYCLES = NUM_SHARDS_DEF + 8;
  localparam int BATCH_ITEMS   = 75;
  localparam logic [ADD_W-1:0] ADD_MAX = {ADD_W{1'b1}};
  localparam logic [CMD_W-1:0] CMD_TOP = {CMD_W{1'b1}};

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic [CMD_W-1:0]     command = '0;
  logic [SHARD_W-1:0]   shard = '0;
  logic [ADD_W-1:0]     add_bytes = '0;
  logic [ADD_W-1:0]     add_points = '0;
  logic                 res_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;

  logic                 cmd_stall;
  logic                 res_valid;
  logic [SHARD_W-1:0]   out_shard;
  logic [CNT_W-1:0]     shard_bytes;
  logic [CNT_W-1:0]     shard_points;
  logic                 shard_over_cap;
  logic                 global_over_cap;
  logic [CNT_W-1:0]     total_bytes;
  logic [CNT_W-1:0]     total_points;
  logic                 found;
  logic                 last;
  logic                 cfg_ready;

  int send_pct = 0;
  int recv_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int commands_sent = 0;
  int lists_sent = 0;
  int mismatches;
  int expected_left;
  int results_checked;

  per_shard_usage_accounting dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .shard(shard), .add_bytes(add_bytes), .add_points(add_points),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_shard(out_shard), .shard_bytes(shard_bytes), .shard_points(shard_points),
    .shard_over_cap(shard_over_cap), .global_over_cap(global_over_cap),
    .total_bytes(total_bytes), .total_points(total_points), .found(found), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  usage_checker accounting_check (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .shard(shard), .add_bytes(add_bytes), .add_points(add_points),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_shard(out_shard), .shard_bytes(shard_bytes), .shard_points(shard_points),
    .shard_over_cap(shard_over_cap), .global_over_cap(global_over_cap),
    .total_bytes(total_bytes), .total_points(total_points), .found(found), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .expected_left(expected_left), .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hold off the result side for a long stretch whenever one is asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < holds_asked) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SHARD_W-1:0] id,
                              input logic [ADD_W-1:0] ab, input logic [ADD_W-1:0] ap);
    while ($urandom_range(0, 99) < send_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid  <= 1'b1;
    command    <= cmd;
    shard      <= id;
    add_bytes  <= ab;
    add_points <= ap;
    do @(posedge clk); while (cmd_stall);
    commands_sent++;
    if (cmd == OP_LIST) lists_sent++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_caps(input logic [CNT_W-1:0] shard_limit,
                          input logic [CNT_W-1:0] global_limit);
    cmd_valid <= 1'b0;
    settle();
    write_register(CFG_SHARD_CAP, shard_limit);
    write_register(CFG_GLOBAL_CAP, global_limit);
  endtask

  function automatic logic [ADD_W-1:0] random_amount();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return ADD_MAX;
    if (pick < 6) return $urandom;
    return $urandom_range(0, 1 << 20);
  endfunction

  function automatic logic [CNT_W-1:0] random_cap(input int msb);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return CNT_W'(v >> (64 - msb)) + 1'b1;
  endfunction

  task automatic random_batch(input int count);
    int                 accepted;
    int                 pick;
    logic [CMD_W-1:0]   cmd;
    logic [SHARD_W-1:0] id;
    accepted = 0;
    while (accepted < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = OP_ADD;
      else if (pick < 60) cmd = OP_QUERY;
      else if (pick < 70) cmd = OP_RESET;
      else if (pick < 73) cmd = OP_RESET_ALL;
      else if (pick < 93) cmd = OP_LIST;
      else cmd = CMD_W'($urandom_range(int'(OP_LIST) + 1, int'(CMD_TOP)));
      // favor a few busy shards so that caps get crossed
      if ($urandom_range(0, 9) < 7) id = SHARD_W'($urandom_range(0, 7));
      else id = SHARD_W'($urandom);
      send_command(cmd, id, random_amount(), random_amount());
      if (cmd <= OP_LIST) accepted++;
    end
  endtask

  initial begin : stimulus
    int c;
    send_pct = 23;
    recv_pct = 47;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_caps('0, '0);
    send_command(OP_ADD, SHARD_W'(0), ADD_MAX, ADD_MAX);
    send_command(OP_LIST, SHARD_W'(0), '0, '0);
    send_command(OP_QUERY, SHARD_W'(0), '0, '0);

    set_caps(CNT_W'(ADD_MAX), CNT_W'(2) * CNT_W'(ADD_MAX));
    send_command(OP_ADD, SHARD_W'(63), '0, '0);
    send_command(OP_ADD, SHARD_W'(63), ADD_MAX, '0);
    send_command(OP_ADD, SHARD_W'(0), ADD_MAX, ADD_MAX);
    send_command(OP_LIST, SHARD_W'(17), ADD_MAX, ADD_MAX);
    send_command(OP_QUERY, SHARD_W'(63), '0, '0);
    send_command(OP_RESET, SHARD_W'(0), '0, '0);
    send_command(OP_QUERY, SHARD_W'(0), '0, '0);
    for (c = int'(OP_LIST) + 1; c <= int'(CMD_TOP); c++) begin
      send_command(CMD_W'(c), SHARD_W'(c), ADD_MAX, ADD_MAX);
    end
    send_command(OP_RESET_ALL, SHARD_W'(63), ADD_MAX, ADD_MAX);
    send_command(OP_LIST, SHARD_W'(0), '0, '0);
    send_command(OP_QUERY, SHARD_W'(63), '0, '0);

    set_caps(CNT_W'(1), CNT_W'(1));
    holds_asked++;
    random_batch(BATCH_ITEMS);

    send_pct = 47;
    recv_pct = 23;
    set_caps(random_cap(33), random_cap(36));
    random_batch(BATCH_ITEMS);

    // load one shard heavily, then reset it and a light shard
    send_pct = 0;
    recv_pct = 0;
    set_caps(CNT_MAX, CNT_MAX);
    send_command(OP_RESET_ALL, SHARD_W'(0), '0, '0);
    repeat (LOAD_ADDS) send_command(OP_ADD, SHARD_W'(5), ADD_MAX, ADD_MAX);
    send_command(OP_ADD, SHARD_W'(9), ADD_W'(1000), ADD_W'(2000));
    send_command(OP_LIST, SHARD_W'(0), '0, '0);
    send_command(OP_QUERY, SHARD_W'(5), '0, '0);
    send_command(OP_RESET, SHARD_W'(5), '0, '0);
    send_command(OP_RESET, SHARD_W'(9), '0, '0);
    send_command(OP_QUERY, SHARD_W'(9), '0, '0);

    set_caps(random_cap(34), random_cap(38));
    holds_asked++;
    random_batch(BATCH_ITEMS);

    cmd_valid <= 1'b0;
    settle();
    $display("Sent %0d commands (%0d shard listings) and checked %0d results,",
             commands_sent, lists_sent, results_checked);
    $display("over six cap settings from zero to full scale, with long result holds.");
    if (mismatches == 0 && expected_left == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* per_shard_usage_accounting.f */
rtl/psua_pkg.sv
rtl/psua_ram.sv
rtl/psua_front.sv
rtl/psua_back.sv
rtl/per_shard_usage_accounting.sv
bench/usage_checker.sv
bench/testbench.sv
